// ===== design/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;
  localparam int FIELD_W       = 11;
  localparam int MUL_STEPS     = 30;
  localparam int MUL_CNT_W     = 5;

  localparam logic [29:0] MODULUS = 30'd998244353;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_EDGE   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] COLOR_ZERO   = 2'd0;
  localparam logic [1:0] COLOR_UNUSED = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_HEAD_CLR,
    OP_START,
    OP_EDGE_LATCH,
    OP_EDGE_DROP,
    OP_RD_A,
    OP_WR_A,
    OP_RD_B,
    OP_WR_B,
    OP_FINISH_INIT,
    OP_COLOR_CLR,
    OP_SEED_RD,
    OP_SEED_NEXT,
    OP_SEED_GO,
    OP_POP,
    OP_NODE_RD,
    OP_NODE_LAT,
    OP_LINK,
    OP_TGT,
    OP_NB,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_OUT_OK,
    OP_OUT_FAIL
  } op_t;

  typedef enum logic [4:0] {
    S_HCLR,
    S_IDLE,
    S_ECHK,
    S_EWA,
    S_ERB,
    S_EWB,
    S_CCLR,
    S_SEED,
    S_SCHK,
    S_POP,
    S_NRD,
    S_NLAT,
    S_LINK,
    S_TGT,
    S_NB,
    S_MINIT,
    S_MUL,
    S_OUTOK,
    S_OUTFAIL
  } state_t;

  typedef struct packed {
    logic sweep_last;
    logic edge_bad;
    logic seeds_done;
    logic seed_colored;
    logic stack_empty;
    logic link_null;
    logic nb_conflict;
    logic mul_last;
    logic out_busy;
  } status_t;

  // Sum of two residues, reduced once.
  function automatic logic [29:0] add_mod(input logic [29:0] x, input logic [29:0] y);
    logic [30:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
    return s[29:0];
  endfunction

endpackage

// ===== design/bipartite_coloring_counter_top.sv =====
// Channel   Dir  Group             Contents
// ------------------------------------------------------------------------
// s_*       in   tvalid/tready     graph items: start, edge, finish
// m_*       out  tvalid/tready     one result item per finish item
//
// Steps: an edge item runs a check, then a head read and a link write per
// direction; a start item runs the head-table clearing sweep. A finish item
// clears the colors, then works through each node, each popped node and each
// stored slot, and runs a bit-serial modular multiply per component, all paced
// by the one read port on each adjacency memory. After reset the head table is
// cleared with s_tready low. A stalled result holds in the output register;
// the next item is still taken while it waits.
module bipartite_coloring_counter_top #(
  parameter int MAX_NODES = bcc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = bcc_pkg::MAX_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // action[1:0], node_count[12:2], end_a[23:13], end_b[34:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // bipartite[0], ways[30:1], dropped[31]
);

  bcc_pkg::op_t     cmd;
  bcc_pkg::status_t st;

  // Sequencer: walks start, edge and finish work one step a cycle, holding while a stalled result blocks the output.
  bcc_controller u_ctrl (
    .clk,
    .rst,
    .s_tvalid,
    .action   (s_tdata[1:0]),
    .st,
    .s_tready,
    .cmd
  );

  // Adjacency lists, color table, walk stack and modular arithmetic.
  bcc_datapath #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_dp (
    .clk,
    .rst,
    .cmd,
    .node_count (s_tdata[12:2]),
    .end_a      (s_tdata[23:13]),
    .end_b      (s_tdata[34:24]),
    .m_tready,
    .st,
    .m_tvalid,
    .m_tdata
  );

endmodule

// ===== design/bcc_ram.sv =====
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bcc_datapath.sv =====
module bcc_datapath #(
  parameter int MAX_NODES = bcc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = bcc_pkg::MAX_EDGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bcc_pkg::op_t              cmd,
  input  logic [bcc_pkg::FIELD_W-1:0] node_count,
  input  logic [bcc_pkg::FIELD_W-1:0] end_a,
  input  logic [bcc_pkg::FIELD_W-1:0] end_b,
  input  logic                      m_tready,
  output bcc_pkg::status_t          st,
  output logic                      m_tvalid,
  output logic [31:0]               m_tdata
);

  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int CMPW  = (CW > bcc_pkg::FIELD_W) ? CW : bcc_pkg::FIELD_W;

  logic [CW-1:0]   n_use;
  logic [LW-1:0]   sc;
  logic            ovf;
  logic [NW-1:0]   cnt;
  logic [CMPW-1:0] a_ext, b_ext;
  logic [CW-1:0]   s;
  logic [CW-1:0]   top;
  logic [NW-1:0]   nb;
  logic            ncol;
  logic [LW-1:0]   link;
  logic [29:0]     p0, p1, prod, acc, addend;
  logic [bcc_pkg::MUL_CNT_W-1:0] bitcnt;
  logic            out_valid, out_bip, out_drop;
  logic [29:0]     out_ways;

  logic [LW-1:0]   head_rd, next_rd;
  logic [NW-1:0]   target_rd, stack_rd;
  logic [1:0]      color_rd;

  logic [NW-1:0]   a_idx, b_idx, s_idx, top_idx, pop_idx;
  logic [SW-1:0]   slot_idx, link_idx;
  logic [CMPW-1:0] n_ext, n_clamp;
  logic            nb_free, can_push;
  logic [29:0]     mul_add, mul_next;

  logic            head_we;
  logic [NW-1:0]   head_waddr, head_raddr;
  logic [LW-1:0]   head_wdata;
  logic            color_we;
  logic [NW-1:0]   color_waddr, color_raddr;
  logic [1:0]      color_wdata;
  logic            stack_we;
  logic [NW-1:0]   stack_waddr, stack_wdata;
  logic            link_we;
  logic [NW-1:0]   target_wdata;

  assign a_idx    = a_ext[NW-1:0] - NW'(1);
  assign b_idx    = b_ext[NW-1:0] - NW'(1);
  assign s_idx    = s[NW-1:0];
  assign top_idx  = top[NW-1:0];
  assign pop_idx  = NW'(top - CW'(1));
  assign slot_idx = sc[SW-1:0];
  assign link_idx = SW'(link - LW'(1));
  assign nb_free  = (color_rd == bcc_pkg::COLOR_UNUSED);
  assign can_push = (top < CW'(MAX_NODES));

  always_comb begin
    n_ext   = CMPW'(node_count);
    n_clamp = n_ext;
    if (n_ext == '0) n_clamp = CMPW'(1);
    else if (n_ext > CMPW'(MAX_NODES)) n_clamp = CMPW'(MAX_NODES);
  end

  assign mul_add  = prod[bitcnt] ? addend : 30'd0;
  assign mul_next = bcc_pkg::add_mod(bcc_pkg::add_mod(acc, acc), mul_add);

  // Memory port steering.
  always_comb begin
    head_we    = (cmd == bcc_pkg::OP_HEAD_CLR) || (cmd == bcc_pkg::OP_WR_A) ||
                 (cmd == bcc_pkg::OP_WR_B);
    head_waddr = (cmd == bcc_pkg::OP_HEAD_CLR) ? cnt :
                 (cmd == bcc_pkg::OP_WR_A) ? a_idx : b_idx;
    head_wdata = (cmd == bcc_pkg::OP_HEAD_CLR) ? '0 : LW'(sc + LW'(1));
    head_raddr = (cmd == bcc_pkg::OP_RD_A) ? a_idx :
                 (cmd == bcc_pkg::OP_RD_B) ? b_idx : stack_rd;

    link_we      = (cmd == bcc_pkg::OP_WR_A) || (cmd == bcc_pkg::OP_WR_B);
    target_wdata = (cmd == bcc_pkg::OP_WR_A) ? b_idx : a_idx;

    color_we    = (cmd == bcc_pkg::OP_COLOR_CLR) || (cmd == bcc_pkg::OP_SEED_GO) ||
                  ((cmd == bcc_pkg::OP_NB) && nb_free);
    color_waddr = (cmd == bcc_pkg::OP_COLOR_CLR) ? cnt :
                  (cmd == bcc_pkg::OP_SEED_GO) ? s_idx : nb;
    color_wdata = (cmd == bcc_pkg::OP_COLOR_CLR) ? bcc_pkg::COLOR_UNUSED :
                  (cmd == bcc_pkg::OP_SEED_GO) ? bcc_pkg::COLOR_ZERO : {1'b0, ~ncol};
    color_raddr = (cmd == bcc_pkg::OP_SEED_RD) ? s_idx :
                  (cmd == bcc_pkg::OP_NODE_RD) ? stack_rd : target_rd;

    stack_we    = (cmd == bcc_pkg::OP_SEED_GO) ||
                  ((cmd == bcc_pkg::OP_NB) && nb_free && can_push);
    stack_waddr = (cmd == bcc_pkg::OP_SEED_GO) ? '0 : top_idx;
    stack_wdata = (cmd == bcc_pkg::OP_SEED_GO) ? s_idx : nb;
  end

  bcc_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );

  bcc_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next (
    .clk, .we(link_we), .waddr(slot_idx), .wdata(head_rd),
    .raddr(link_idx), .rdata(next_rd)
  );

  bcc_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_target (
    .clk, .we(link_we), .waddr(slot_idx), .wdata(target_wdata),
    .raddr(link_idx), .rdata(target_rd)
  );

  bcc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_color (
    .clk, .we(color_we), .waddr(color_waddr), .wdata(color_wdata),
    .raddr(color_raddr), .rdata(color_rd)
  );

  bcc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
    .raddr(pop_idx), .rdata(stack_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n_use     <= CW'(1);
      sc        <= '0;
      ovf       <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((cmd == bcc_pkg::OP_OUT_OK) || (cmd == bcc_pkg::OP_OUT_FAIL)) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      case (cmd)
        bcc_pkg::OP_HEAD_CLR, bcc_pkg::OP_COLOR_CLR: cnt <= NW'(cnt + NW'(1));
        bcc_pkg::OP_START: begin
          n_use <= CW'(n_clamp);
          sc    <= '0;
          ovf   <= 1'b0;
          cnt   <= '0;
        end
        bcc_pkg::OP_EDGE_DROP: ovf <= 1'b1;
        bcc_pkg::OP_WR_A, bcc_pkg::OP_WR_B: sc <= LW'(sc + LW'(1));
        bcc_pkg::OP_FINISH_INIT: cnt <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      bcc_pkg::OP_EDGE_LATCH: begin
        a_ext <= CMPW'(end_a);
        b_ext <= CMPW'(end_b);
      end
      bcc_pkg::OP_FINISH_INIT: begin
        prod <= 30'd1;
        s    <= '0;
      end
      bcc_pkg::OP_SEED_NEXT: s <= CW'(s + CW'(1));
      bcc_pkg::OP_SEED_GO: begin
        p0  <= 30'd2;
        p1  <= 30'd1;
        top <= CW'(1);
      end
      bcc_pkg::OP_POP: top <= CW'(top - CW'(1));
      bcc_pkg::OP_NODE_LAT: begin
        link <= head_rd;
        ncol <= color_rd[0];
      end
      bcc_pkg::OP_TGT: begin
        nb   <= target_rd;
        link <= next_rd;
      end
      bcc_pkg::OP_NB: begin
        if (nb_free) begin
          if (ncol) p0 <= bcc_pkg::add_mod(p0, p0);
          else p1 <= bcc_pkg::add_mod(p1, p1);
          if (can_push) top <= CW'(top + CW'(1));
        end
      end
      bcc_pkg::OP_MUL_INIT: begin
        addend <= bcc_pkg::add_mod(p0, p1);
        acc    <= '0;
        bitcnt <= bcc_pkg::MUL_CNT_W'(bcc_pkg::MUL_STEPS - 1);
      end
      bcc_pkg::OP_MUL_STEP: begin
        acc    <= mul_next;
        bitcnt <= bitcnt - bcc_pkg::MUL_CNT_W'(1);
        if (bitcnt == '0) begin
          prod <= mul_next;
          s    <= CW'(s + CW'(1));
        end
      end
      bcc_pkg::OP_OUT_OK: begin
        out_bip  <= 1'b1;
        out_ways <= prod;
        out_drop <= ovf;
      end
      bcc_pkg::OP_OUT_FAIL: begin
        out_bip  <= 1'b0;
        out_ways <= '0;
        out_drop <= ovf;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.sweep_last   = (cnt == NW'(MAX_NODES - 1));
    st.edge_bad     = (a_ext == '0) || (b_ext == '0) || (a_ext > CMPW'(n_use)) ||
                      (b_ext > CMPW'(n_use)) ||
                      (({1'b0, sc} + (LW + 1)'(2)) > (LW + 1)'(SLOTS));
    st.seeds_done   = (s == n_use);
    st.seed_colored = !nb_free;
    st.stack_empty  = (top == '0);
    st.link_null    = (link == '0);
    st.nb_conflict  = (color_rd == {1'b0, ncol});
    st.mul_last     = (bitcnt == '0);
    st.out_busy     = out_valid && !m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_drop, out_ways, out_bip};

endmodule

// ===== design/bcc_controller.sv =====
module bcc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [1:0]       action,
  input  bcc_pkg::status_t st,
  output logic             s_tready,
  output bcc_pkg::op_t     cmd
);

  bcc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bcc_pkg::S_HCLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bcc_pkg::S_HCLR: if (st.sweep_last) state_next = bcc_pkg::S_IDLE;
      bcc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (action)
            bcc_pkg::ACT_START:  state_next = bcc_pkg::S_HCLR;
            bcc_pkg::ACT_EDGE:   state_next = bcc_pkg::S_ECHK;
            bcc_pkg::ACT_FINISH: state_next = bcc_pkg::S_CCLR;
            default:             state_next = bcc_pkg::S_IDLE;
          endcase
        end
      end
      bcc_pkg::S_ECHK: state_next = st.edge_bad ? bcc_pkg::S_IDLE : bcc_pkg::S_EWA;
      bcc_pkg::S_EWA:  state_next = bcc_pkg::S_ERB;
      bcc_pkg::S_ERB:  state_next = bcc_pkg::S_EWB;
      bcc_pkg::S_EWB:  state_next = bcc_pkg::S_IDLE;
      bcc_pkg::S_CCLR: if (st.sweep_last) state_next = bcc_pkg::S_SEED;
      bcc_pkg::S_SEED: state_next = st.seeds_done ? bcc_pkg::S_OUTOK : bcc_pkg::S_SCHK;
      bcc_pkg::S_SCHK: state_next = st.seed_colored ? bcc_pkg::S_SEED : bcc_pkg::S_POP;
      bcc_pkg::S_POP:  state_next = st.stack_empty ? bcc_pkg::S_MINIT : bcc_pkg::S_NRD;
      bcc_pkg::S_NRD:  state_next = bcc_pkg::S_NLAT;
      bcc_pkg::S_NLAT: state_next = bcc_pkg::S_LINK;
      bcc_pkg::S_LINK: state_next = st.link_null ? bcc_pkg::S_POP : bcc_pkg::S_TGT;
      bcc_pkg::S_TGT:  state_next = bcc_pkg::S_NB;
      bcc_pkg::S_NB:   state_next = st.nb_conflict ? bcc_pkg::S_OUTFAIL : bcc_pkg::S_LINK;
      bcc_pkg::S_MINIT: state_next = bcc_pkg::S_MUL;
      bcc_pkg::S_MUL:  if (st.mul_last) state_next = bcc_pkg::S_SEED;
      bcc_pkg::S_OUTOK, bcc_pkg::S_OUTFAIL: if (!st.out_busy) state_next = bcc_pkg::S_IDLE;
      default: state_next = bcc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = bcc_pkg::OP_NONE;
    s_tready = 1'b0;
    case (state)
      bcc_pkg::S_HCLR: cmd = bcc_pkg::OP_HEAD_CLR;
      bcc_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (action)
            bcc_pkg::ACT_START:  cmd = bcc_pkg::OP_START;
            bcc_pkg::ACT_EDGE:   cmd = bcc_pkg::OP_EDGE_LATCH;
            bcc_pkg::ACT_FINISH: cmd = bcc_pkg::OP_FINISH_INIT;
            default:             cmd = bcc_pkg::OP_NONE;
          endcase
        end
      end
      bcc_pkg::S_ECHK: cmd = st.edge_bad ? bcc_pkg::OP_EDGE_DROP : bcc_pkg::OP_RD_A;
      bcc_pkg::S_EWA:  cmd = bcc_pkg::OP_WR_A;
      bcc_pkg::S_ERB:  cmd = bcc_pkg::OP_RD_B;
      bcc_pkg::S_EWB:  cmd = bcc_pkg::OP_WR_B;
      bcc_pkg::S_CCLR: cmd = bcc_pkg::OP_COLOR_CLR;
      bcc_pkg::S_SEED: if (!st.seeds_done) cmd = bcc_pkg::OP_SEED_RD;
      bcc_pkg::S_SCHK: cmd = st.seed_colored ? bcc_pkg::OP_SEED_NEXT : bcc_pkg::OP_SEED_GO;
      bcc_pkg::S_POP:  if (!st.stack_empty) cmd = bcc_pkg::OP_POP;
      bcc_pkg::S_NRD:  cmd = bcc_pkg::OP_NODE_RD;
      bcc_pkg::S_NLAT: cmd = bcc_pkg::OP_NODE_LAT;
      bcc_pkg::S_LINK: if (!st.link_null) cmd = bcc_pkg::OP_LINK;
      bcc_pkg::S_TGT:  cmd = bcc_pkg::OP_TGT;
      bcc_pkg::S_NB:   if (!st.nb_conflict) cmd = bcc_pkg::OP_NB;
      bcc_pkg::S_MINIT: cmd = bcc_pkg::OP_MUL_INIT;
      bcc_pkg::S_MUL:  cmd = bcc_pkg::OP_MUL_STEP;
      bcc_pkg::S_OUTOK:   if (!st.out_busy) cmd = bcc_pkg::OP_OUT_OK;
      bcc_pkg::S_OUTFAIL: if (!st.out_busy) cmd = bcc_pkg::OP_OUT_FAIL;
      default: cmd = bcc_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/bcc_checker.sv =====
`include "assert_macros.svh"

module bcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  `BCC_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `BCC_ASSERT_SAME(a_fail_zero, m_tvalid && !m_tdata[0], m_tdata[30:1] == 30'd0, "ways nonzero")
  `BCC_ASSERT_SAME(a_reduced, m_tvalid, m_tdata[30:1] < bcc_pkg::MODULUS, "ways not reduced")
  `BCC_ASSERT_SAME(a_clear_busy, $past(rst), !s_tready, "ready during head clearing")

endmodule

bind bipartite_coloring_counter_top bcc_checker u_bcc_checker (.*);
